// ----- hdl/ftd_pkg.sv -----
// Package for the finite-time tracking differentiator: widths, register
// indexes, sequencer states, control struct, saturation helpers and the
// log2/exp2 tables. No dependencies.
package ftd_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int FRAC_BITS      = 20;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_Q          = 16;
    localparam int MANT_Q         = 30;
    localparam int TBL_N          = (1 << LOG_TABLE_BITS) + 1;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;

    localparam logic [2:0] CFG_GAIN_POS_ROLL   = 3'd0;
    localparam logic [2:0] CFG_GAIN_POS_PITCH  = 3'd1;
    localparam logic [2:0] CFG_GAIN_RATE_ROLL  = 3'd2;
    localparam logic [2:0] CFG_GAIN_RATE_PITCH = 3'd3;
    localparam logic [2:0] CFG_TIME_STEP       = 3'd4;
    localparam logic [2:0] CFG_LOW_EXPONENT    = 3'd5;
    localparam logic [2:0] CFG_HIGH_EXPONENT   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_NORM, ST_LOGM, ST_LOGA,
        ST_ZM, ST_ZR, ST_XM, ST_XR, ST_GM, ST_GA,
        ST_VM, ST_VA, ST_PM, ST_PA, ST_DONE
    } state_t;

    typedef struct packed {
        state_t     state;
        logic       ch;
        logic [1:0] j;
        logic [2:0] k;
        logic       s_ready;
        logic       out_load;
    } ctl_t;

    typedef struct packed {
        logic [30:0] gain_pos_roll;
        logic [30:0] gain_pos_pitch;
        logic [30:0] gain_rate_roll;
        logic [30:0] gain_rate_pitch;
        logic [20:0] time_step;
        logic [14:0] low_exponent;
        logic [15:0] high_exponent;
    } cfg_t;

    typedef logic [16:0] log_tbl_t [TBL_N];
    typedef logic [31:0] exp_tbl_t [TBL_N];

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bv;
        logic [63:0] nn;
        res = 64'd0;
        nn  = n;
        for (int i = 0; i < 32; i++) begin
            bv = 64'd1 << (62 - 2 * i);
            if (nn >= res + bv) begin
                nn  = nn - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic log_tbl_t build_log_rom();
        log_tbl_t    t;
        logic [63:0] y;
        logic [16:0] r;
        for (int i = 0; i < TBL_N - 1; i++) begin
            y = (64'd1 << MANT_Q) + (64'(i) << (MANT_Q - LOG_TABLE_BITS));
            r = '0;
            for (int k = 1; k <= LOG_Q; k++) begin
                y = (y * y) >> MANT_Q;
                if (y >= (64'd2 << MANT_Q)) begin
                    y = y >> 1;
                    r = r | (17'd1 << (LOG_Q - k));
                end
            end
            t[i] = r;
        end
        t[TBL_N - 1] = 17'd1 << LOG_Q;
        return t;
    endfunction

    function automatic exp_tbl_t build_exp_rom();
        exp_tbl_t    t;
        logic [63:0] root [LOG_TABLE_BITS + 1];
        logic [63:0] acc;
        root[0] = 64'd2 << MANT_Q;
        for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
            root[k] = isqrt64(root[k - 1] << MANT_Q);
        end
        for (int i = 0; i < TBL_N - 1; i++) begin
            acc = 64'd1 << MANT_Q;
            for (int k = 0; k < LOG_TABLE_BITS; k++) begin
                if (((i >> k) & 1) != 0) begin
                    acc = (acc * root[LOG_TABLE_BITS - k]) >> MANT_Q;
                end
            end
            t[i] = acc[31:0];
        end
        t[TBL_N - 1] = 32'h8000_0000;
        return t;
    endfunction

    localparam log_tbl_t LOG_ROM = build_log_rom();
    localparam exp_tbl_t EXP_ROM = build_exp_rom();

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? VAL_MIN : VAL_MAX;
        end
        return v[31:0];
    endfunction

    // product magnitude >> FRAC_BITS, capped, then signed and saturated
    function automatic logic signed [31:0] fmul_res(input logic [PROD_W-1:0] p,
                                                    input logic neg);
        logic [PROD_W-FRAC_BITS-1:0] mag;
        mag = p[PROD_W-1:FRAC_BITS];
        if (mag >= (PROD_W-FRAC_BITS)'(64'h8000_0000)) begin
            return neg ? VAL_MIN : VAL_MAX;
        end
        return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    function automatic logic [17:0] rate_exp(input logic [15:0] p);
        logic signed [18:0] q;
        q = $signed({2'b00, p, 1'b0}) - 19'sd16384;
        return q[18] ? 18'd0 : q[17:0];
    endfunction

endpackage

// ----- hdl/finite_time_tracking_differentiator_top.sv -----
// Top level of the finite-time tracking differentiator: datapath registers,
// table lookups and output register. Depends on ftd_pkg, ftd_cfg, ftd_mul,
// ftd_ctrl.
//
//  channel   handshake           payload
//  input     s_valid / s_ready   s_roll_target .. s_yaw_rate_target
//  result    m_valid / m_ready   m_roll_estimate .. m_pitch_error
//  config    cfg_wr_en           cfg_index, cfg_data
//
// An item passes through both channels in turn on the one shared multiplier
// (five-step normalize, log2, four power terms, rate and position updates),
// then a hand-off to the output register. The next item is accepted only
// once the sequencer is back in idle, not while an item is in flight.
// Synchronous active-low reset clears the estimates, sequencer and m_valid.
// A waiting result does not block the next item; the last step holds until
// the output register is free.
module finite_time_tracking_differentiator_top import ftd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_roll_target,
    input  logic signed [31:0] s_pitch_target,
    input  logic signed [31:0] s_yaw_target,
    input  logic signed [31:0] s_yaw_rate_target,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_roll_estimate,
    output logic signed [31:0] m_pitch_estimate,
    output logic signed [31:0] m_yaw_out,
    output logic signed [31:0] m_roll_rate_estimate,
    output logic signed [31:0] m_pitch_rate_estimate,
    output logic signed [31:0] m_yaw_rate_out,
    output logic signed [31:0] m_roll_error,
    output logic signed [31:0] m_pitch_error,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    cfg_t cfg;
    ctl_t ctl;

    logic                    m_valid_reg;
    logic                    out_free;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0]       prod;

    logic signed [31:0] tgt_reg [2];
    logic signed [31:0] pos_reg [2];
    logic signed [31:0] vel_reg [2];
    logic signed [31:0] err_reg [2];
    logic signed [31:0] yaw_reg, yawr_reg;
    logic [31:0]        nrm_reg;
    logic [4:0]         msb_reg;
    logic signed [21:0] log_reg;
    logic signed [25:0] z_reg;
    logic [31:0]        base_reg;
    logic [30:0]        smag_reg;
    logic signed [31:0] acc_reg;

    logic signed [31:0] o_pos [2];
    logic signed [31:0] o_vel [2];
    logic signed [31:0] o_err [2];
    logic signed [31:0] o_yaw, o_yawr;

    ftd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .ctl      (ctl)
    );

    ftd_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = ctl.s_ready;

    // per-channel operands
    logic signed [31:0] err_cur;
    logic               eneg, ezero;
    logic signed [32:0] diff_e;
    logic signed [31:0] e_sat;
    logic [31:0]        e_mag;
    logic [5:0]         nsh;
    logic               top_zero;
    logic [7:0]         lidx, xidx;
    logic [16:0]        ldiff;
    logic [31:0]        xdiff;
    logic [17:0]        q_cur;
    logic [30:0]        g_cur;
    logic signed [5:0]  ipart;
    logic signed [21:0] log_new;
    logic [31:0]        mant;
    logic signed [10:0] s_exp;
    logic [10:0]        rsh;
    logic [30:0]        r_pow;
    logic signed [31:0] f_term;
    logic [31:0]        acc_mag;

    always_comb begin
        err_cur = err_reg[ctl.ch];
        eneg    = err_cur[31];
        ezero   = (err_cur == 32'sd0);
        diff_e  = 33'(tgt_reg[ctl.ch]) - 33'(pos_reg[ctl.ch]);
        e_sat   = sat33(diff_e);
        e_mag   = e_sat[31] ? 32'(-e_sat) : 32'(e_sat);

        unique case (ctl.k)
            3'd0:    nsh = 6'd16;
            3'd1:    nsh = 6'd8;
            3'd2:    nsh = 6'd4;
            3'd3:    nsh = 6'd2;
            default: nsh = 6'd1;
        endcase
        top_zero = ((nrm_reg >> (6'd32 - nsh)) == 32'd0);

        lidx  = nrm_reg[30:23];
        ldiff = LOG_ROM[9'(lidx) + 9'd1] - LOG_ROM[9'(lidx)];
        xidx  = z_reg[15:8];
        xdiff = EXP_ROM[9'(xidx) + 9'd1] - EXP_ROM[9'(xidx)];

        unique case (ctl.j)
            2'd0:    q_cur = rate_exp({1'b0, cfg.low_exponent});
            2'd1:    q_cur = rate_exp(cfg.high_exponent);
            2'd2:    q_cur = {3'd0, cfg.low_exponent};
            default: q_cur = {2'd0, cfg.high_exponent};
        endcase
        if (ctl.j[1]) begin
            g_cur = ctl.ch ? cfg.gain_pos_pitch : cfg.gain_pos_roll;
        end else begin
            g_cur = ctl.ch ? cfg.gain_rate_pitch : cfg.gain_rate_roll;
        end

        ipart   = $signed({1'b0, msb_reg}) - 6'sd20;
        log_new = $signed({ipart, 16'd0}) + $signed(22'(base_reg[16:0]))
                + $signed(22'(prod[38:22]));

        mant  = base_reg + prod[39:8];
        s_exp = $signed({z_reg[25], z_reg[25:16]}) - 11'sd10;
        rsh   = 11'(-s_exp);
        if (ezero) begin
            r_pow = 31'd0;
        end else if (s_exp > 11'sd0) begin
            r_pow = 31'h7FFF_FFFF;
        end else if (s_exp == 11'sd0) begin
            r_pow = mant[31] ? 31'h7FFF_FFFF : mant[30:0];
        end else if (rsh >= 11'd32) begin
            r_pow = 31'd0;
        end else begin
            r_pow = 31'(mant >> rsh[4:0]);
        end

        f_term  = fmul_res(prod, eneg);
        acc_mag = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);

        mul_a = '0;
        mul_b = '0;
        unique case (ctl.state)
            ST_LOGM: begin
                mul_a = $signed(33'(ldiff));
                mul_b = $signed(33'(nrm_reg[22:1]));
            end
            ST_ZM: begin
                mul_a = 33'(log_reg);
                mul_b = $signed(33'(q_cur));
            end
            ST_XM: begin
                mul_a = $signed(33'(xdiff));
                mul_b = $signed(33'(z_reg[7:0]));
            end
            ST_GM: begin
                mul_a = $signed(33'(g_cur));
                mul_b = $signed(33'(smag_reg));
            end
            ST_VM, ST_PM: begin
                mul_a = $signed({1'b0, acc_mag});
                mul_b = $signed(33'(cfg.time_step));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            vel_reg[0] <= '0;
            vel_reg[1] <= '0;
        end else begin
            unique case (ctl.state)
                ST_VA:   vel_reg[ctl.ch] <= sat33(33'(vel_reg[ctl.ch])
                                                  + 33'(fmul_res(prod, acc_reg[31])));
                ST_PA:   pos_reg[ctl.ch] <= sat33(33'(pos_reg[ctl.ch])
                                                  + 33'(fmul_res(prod, acc_reg[31])));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && ctl.s_ready) begin
            tgt_reg[0] <= s_roll_target;
            tgt_reg[1] <= s_pitch_target;
            yaw_reg    <= s_yaw_target;
            yawr_reg   <= s_yaw_rate_target;
        end
        unique case (ctl.state)
            ST_ERR: begin
                err_reg[ctl.ch] <= e_sat;
                nrm_reg         <= e_mag;
                msb_reg         <= 5'd31;
            end
            ST_NORM: begin
                if (top_zero) begin
                    nrm_reg <= nrm_reg << nsh;
                    msb_reg <= msb_reg - nsh[4:0];
                end
            end
            ST_LOGM: base_reg <= 32'(LOG_ROM[9'(lidx)]);
            ST_LOGA: log_reg  <= log_new;
            ST_ZR:   z_reg    <= prod[39:14];
            ST_XM:   base_reg <= EXP_ROM[9'(xidx)];
            ST_XR:   smag_reg <= r_pow;
            ST_GA: begin
                unique case (ctl.j)
                    2'd0:    acc_reg <= f_term;
                    2'd2:    acc_reg <= sat33(33'(vel_reg[ctl.ch]) + 33'(f_term));
                    default: acc_reg <= sat33(33'(acc_reg) + 33'(f_term));
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            o_pos[0] <= pos_reg[0];
            o_pos[1] <= pos_reg[1];
            o_vel[0] <= vel_reg[0];
            o_vel[1] <= vel_reg[1];
            o_err[0] <= err_reg[0];
            o_err[1] <= err_reg[1];
            o_yaw    <= yaw_reg;
            o_yawr   <= yawr_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_roll_estimate       = o_pos[0];
    assign m_pitch_estimate      = o_pos[1];
    assign m_yaw_out             = o_yaw;
    assign m_roll_rate_estimate  = o_vel[0];
    assign m_pitch_rate_estimate = o_vel[1];
    assign m_yaw_rate_out        = o_yawr;
    assign m_roll_error          = o_err[0];
    assign m_pitch_error         = o_err[1];

endmodule

// ----- hdl/ftd_cfg.sv -----
// Configuration register file: gains, time step and exponents.
// Depends on ftd_pkg.
module ftd_cfg import ftd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_pos_roll   <= 31'd4194304;
            cfg_reg.gain_pos_pitch  <= 31'd4194304;
            cfg_reg.gain_rate_roll  <= 31'd5242880;
            cfg_reg.gain_rate_pitch <= 31'd5242880;
            cfg_reg.time_step       <= 21'd20972;
            cfg_reg.low_exponent    <= 15'd11469;
            cfg_reg.high_exponent   <= 16'd19661;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAIN_POS_ROLL:   cfg_reg.gain_pos_roll   <= cfg_data;
                CFG_GAIN_POS_PITCH:  cfg_reg.gain_pos_pitch  <= cfg_data;
                CFG_GAIN_RATE_ROLL:  cfg_reg.gain_rate_roll  <= cfg_data;
                CFG_GAIN_RATE_PITCH: cfg_reg.gain_rate_pitch <= cfg_data;
                CFG_TIME_STEP:       cfg_reg.time_step       <= cfg_data[20:0];
                CFG_LOW_EXPONENT:    cfg_reg.low_exponent    <= cfg_data[14:0];
                CFG_HIGH_EXPONENT:   cfg_reg.high_exponent   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/ftd_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on ftd_pkg.
module ftd_mul import ftd_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic        [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/ftd_ctrl.sv -----
// Sequencer: steps the channel, exponent and normalize counters through
// the shared datapath. Depends on ftd_pkg.
module ftd_ctrl import ftd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic out_free,
    output ctl_t ctl
);

    state_t     state_reg, state_next;
    logic       ch_reg, ch_next;
    logic [1:0] j_reg, j_next;
    logic [2:0] k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            j_reg     <= 2'd0;
            k_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ERR;
                    ch_next    = 1'b0;
                end
            end
            ST_ERR: begin
                state_next = ST_NORM;
                k_next     = 3'd0;
            end
            ST_NORM: begin
                if (k_reg == 3'd4) begin
                    state_next = ST_LOGM;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_LOGM: state_next = ST_LOGA;
            ST_LOGA: begin
                state_next = ST_ZM;
                j_next     = 2'd0;
            end
            ST_ZM: state_next = ST_ZR;
            ST_ZR: state_next = ST_XM;
            ST_XM: state_next = ST_XR;
            ST_XR: state_next = ST_GM;
            ST_GM: state_next = ST_GA;
            ST_GA: begin
                if (j_reg == 2'd1) begin
                    state_next = ST_VM;
                end else if (j_reg == 2'd3) begin
                    state_next = ST_PM;
                end else begin
                    state_next = ST_ZM;
                    j_next     = j_reg + 2'd1;
                end
            end
            ST_VM: state_next = ST_VA;
            ST_VA: begin
                state_next = ST_ZM;
                j_next     = 2'd2;
            end
            ST_PM: state_next = ST_PA;
            ST_PA: begin
                if (ch_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ERR;
                    ch_next    = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.state    = state_reg;
        ctl.ch       = ch_reg;
        ctl.j        = j_reg;
        ctl.k        = k_reg;
        ctl.s_ready  = (state_reg == ST_IDLE);
        ctl.out_load = (state_reg == ST_DONE) && out_free;
    end

endmodule

// ----- bench/ftd_checker.sv -----
// Checker for the finite-time tracking differentiator: tracks config writes,
// predicts each result from accepted items and compares it field by field.
// Depends on ftd_pkg for register indexes.
`timescale 1ns / 1ps

module ftd_checker import ftd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_roll_target,
    input  logic signed [31:0] s_pitch_target,
    input  logic signed [31:0] s_yaw_target,
    input  logic signed [31:0] s_yaw_rate_target,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_roll_estimate,
    input  logic signed [31:0] m_pitch_estimate,
    input  logic signed [31:0] m_yaw_out,
    input  logic signed [31:0] m_roll_rate_estimate,
    input  logic signed [31:0] m_pitch_rate_estimate,
    input  logic signed [31:0] m_yaw_rate_out,
    input  logic signed [31:0] m_roll_error,
    input  logic signed [31:0] m_pitch_error,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam longint TOP = 64'sd2147483647;
    localparam longint BOT = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] f [8];
    } track_t;

    track_t tracks [$];

    longint     lg_tbl [257];
    logic [63:0] ex_tbl [257];

    logic [30:0] g_pos [2];
    logic [30:0] g_rate [2];
    logic [20:0] dt;
    logic [14:0] alpha;
    logic [15:0] beta;
    longint      pos [2];
    longint      vel [2];

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bv;
        res = 0;
        bv  = 64'd1 << 62;
        while (bv > n) bv = bv >> 2;
        while (bv != 0) begin
            if (n >= res + bv) begin
                n   = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    initial begin
        logic [63:0] root [9];
        logic [63:0] y;
        logic [63:0] acc;
        longint      r;
        root[0] = 64'd2 << 30;
        for (int k = 1; k <= 8; k++) root[k] = int_sqrt(root[k - 1] << 30);
        for (int i = 0; i < 256; i++) begin
            y   = (64'd1 << 30) + (64'(i) << 22);
            r   = 0;
            acc = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    r = r | (64'sd1 << (16 - k));
                end
            end
            lg_tbl[i] = r;
            for (int k = 0; k < 8; k++)
                if (((i >> k) & 1) != 0) acc = (acc * root[8 - k]) >> 30;
            ex_tbl[i] = acc;
        end
        lg_tbl[256] = 64'sd1 << 16;
        ex_tbl[256] = 64'd2 << 30;
    end

    function automatic longint clamp32(input longint v);
        return v > TOP ? TOP : (v < BOT ? BOT : v);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] x;
        logic [127:0] y;
        logic [127:0] p;
        longint       m;
        x = a < 0 ? 128'(-a) : 128'(a);
        y = b < 0 ? 128'(-b) : 128'(b);
        p = (x * y) >> 20;
        if (p > 128'h8000_0000) p = 128'h8000_0000;
        m = longint'(p[63:0]);
        return clamp32(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint log2q(input logic [63:0] x);
        int          m;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] idx;
        logic [63:0] rem;
        m = 0;
        for (int i = 0; i < 64; i++) if (x[i]) m = i;
        mant = m >= 30 ? x >> (m - 30) : x << (30 - m);
        frac = mant - (64'd1 << 30);
        idx  = frac >> 22;
        rem  = frac & ((64'd1 << 22) - 1);
        return longint'(m - 20) * 65536 + lg_tbl[idx]
             + longint'((64'(lg_tbl[idx + 1] - lg_tbl[idx]) * rem) >> 22);
    endfunction

    function automatic longint pow2q(input longint z);
        longint      ip;
        longint      s;
        logic [63:0] fp;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] mant;
        logic [63:0] v;
        ip   = z >>> 16;
        fp   = 64'(z - ip * 65536);
        idx  = fp >> 8;
        rem  = fp & 64'hFF;
        mant = ex_tbl[idx] + (((ex_tbl[idx + 1] - ex_tbl[idx]) * rem) >> 8);
        s    = ip - 10;
        if (s < 0) return s < -40 ? 0 : longint'(mant >> (-s));
        if (s >= 33) return TOP;
        v = mant << s;
        return v > 64'(TOP) ? TOP : longint'(v);
    endfunction

    function automatic longint signed_pow(input longint e, input longint q);
        longint r;
        if (e == 0) return 0;
        r = pow2q((log2q(64'(e < 0 ? -e : e)) * q) >>> 14);
        return e < 0 ? -r : r;
    endfunction

    function automatic longint rate_power(input longint p);
        longint q;
        q = 2 * p - 16384;
        return q < 0 ? 0 : q;
    endfunction

    function automatic longint track_axis(input int c, input longint target);
        longint e;
        longint d;
        longint g1;
        longint g2;
        g1 = longint'(g_pos[c]);
        g2 = longint'(g_rate[c]);
        e  = clamp32(target - pos[c]);
        d  = clamp32(qmul(g2, signed_pow(e, rate_power(alpha)))
                   + qmul(g2, signed_pow(e, rate_power(beta))));
        vel[c] = clamp32(vel[c] + qmul(d, longint'(dt)));
        d  = clamp32(vel[c] + qmul(g1, signed_pow(e, longint'(alpha))));
        d  = clamp32(d + qmul(g1, signed_pow(e, longint'(beta))));
        pos[c] = clamp32(pos[c] + qmul(d, longint'(dt)));
        return e;
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge aclk) begin
        track_t t;
        track_t got;
        bit     bad;
        if (!aresetn) begin
            g_pos  = '{31'd4194304, 31'd4194304};
            g_rate = '{31'd5242880, 31'd5242880};
            dt     = 21'd20972;
            alpha  = 15'd11469;
            beta   = 16'd19661;
            pos    = '{0, 0};
            vel    = '{0, 0};
            tracks.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.f = '{m_roll_estimate, m_pitch_estimate, m_yaw_out,
                          m_roll_rate_estimate, m_pitch_rate_estimate, m_yaw_rate_out,
                          m_roll_error, m_pitch_error};
                if (tracks.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("%0t: result with none expected", $realtime);
                end else begin
                    t   = tracks.pop_front();
                    bad = 0;
                    for (int i = 0; i < 8; i++) if (t.f[i] !== got.f[i]) bad = 1;
                    checked++;
                    if (bad) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch item %0d exp %p got %p",
                                     $realtime, checked, t.f, got.f);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_GAIN_POS_ROLL:   g_pos[0]  = cfg_data;
                    CFG_GAIN_POS_PITCH:  g_pos[1]  = cfg_data;
                    CFG_GAIN_RATE_ROLL:  g_rate[0] = cfg_data;
                    CFG_GAIN_RATE_PITCH: g_rate[1] = cfg_data;
                    CFG_TIME_STEP:       dt        = cfg_data[20:0];
                    CFG_LOW_EXPONENT:    alpha     = cfg_data[14:0];
                    CFG_HIGH_EXPONENT:   beta      = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                t.f[6] = 32'(track_axis(0, longint'(s_roll_target)));
                t.f[7] = 32'(track_axis(1, longint'(s_pitch_target)));
                t.f[0] = 32'(pos[0]);
                t.f[1] = 32'(pos[1]);
                t.f[2] = s_yaw_target;
                t.f[3] = 32'(vel[0]);
                t.f[4] = 32'(vel[1]);
                t.f[5] = s_yaw_rate_target;
                tracks.push_back(t);
            end
        end
        pending <= tracks.size();
    end

endmodule

// ----- bench/tb_finite_time_tracking_differentiator_top.sv -----
// Testbench top for the finite-time tracking differentiator: drives items,
// config writes and output stalls, and gives the verdict.
// Depends on ftd_pkg, ftd_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_finite_time_tracking_differentiator_top import ftd_pkg::*;;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_roll_target = 0;
    logic signed [31:0] s_pitch_target = 0;
    logic signed [31:0] s_yaw_target = 0;
    logic signed [31:0] s_yaw_rate_target = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_roll_estimate;
    logic signed [31:0] m_pitch_estimate;
    logic signed [31:0] m_yaw_out;
    logic signed [31:0] m_roll_rate_estimate;
    logic signed [31:0] m_pitch_rate_estimate;
    logic signed [31:0] m_yaw_rate_out;
    logic signed [31:0] m_roll_error;
    logic signed [31:0] m_pitch_error;
    logic               cfg_wr_en = 0;
    logic [2:0]         cfg_index = 0;
    logic [30:0]        cfg_data = 0;

    int errors;
    int pending;
    int checked;
    int idle_cycles;
    bit gaps_on;
    int settings_run;

    finite_time_tracking_differentiator_top u_top (.*);

    ftd_checker u_chk (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver stalls
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 0;
                stall--;
            end else begin
                m_ready <= 1;
                if (gaps_on && $urandom_range(0, 9) < 3)
                    stall = $urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 4);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 20000) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("FAIL finite_time_tracking_differentiator_top");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [31:0] r, input logic [31:0] p,
                             input logic [31:0] y, input logic [31:0] yr);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 9) < 4)
            gap = $urandom_range(0, 14) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1;
        s_roll_target     <= r;
        s_pitch_target    <= p;
        s_yaw_target      <= y;
        s_yaw_rate_target <= yr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending != 0 || m_valid);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic load_settings(input logic [30:0] g1r, input logic [30:0] g1p,
                                 input logic [30:0] g2r, input logic [30:0] g2p,
                                 input logic [20:0] step, input logic [14:0] a,
                                 input logic [15:0] b);
        write_reg(CFG_GAIN_POS_ROLL, g1r);
        write_reg(CFG_GAIN_POS_PITCH, g1p);
        write_reg(CFG_GAIN_RATE_ROLL, g2r);
        write_reg(CFG_GAIN_RATE_PITCH, g2p);
        write_reg(CFG_TIME_STEP, 31'(step));
        write_reg(CFG_LOW_EXPONENT, 31'(a));
        write_reg(CFG_HIGH_EXPONENT, 31'(b));
        @(posedge aclk);
        cfg_wr_en <= 0;
        settings_run++;
    endtask

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    task automatic random_items(input int n);
        logic [31:0] r;
        logic [31:0] p;
        r = pick_target();
        p = pick_target();
        for (int i = 0; i < n; i++) begin
            // hold a set point for a while so the estimates converge
            if ($urandom_range(0, 7) == 0) r = pick_target();
            if ($urandom_range(0, 7) == 0) p = pick_target();
            send_item(r, p, $urandom, $urandom);
        end
    endtask

    initial begin
        gaps_on      = 0;
        settings_run = 1;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed, reset settings: zero error first, then extremes
        send_item(0, 0, 0, 0);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0010_0000, 32'hFFF0_0000, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(1, -1, 32'hAAAA_AAAA, 32'h5555_5555);
        for (int i = 0; i < 6; i++) send_item(32'h0008_0000, 32'hFFFC_0000, i, -i);
        drain();

        // zero step: estimates hold, errors still reported
        load_settings(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0, 21'd0, 15'd8192, 16'd16384);
        send_item(32'h0010_0000, 32'hFFF0_0000, 1, 2);
        send_item(0, 0, 3, 4);
        drain();
        // exponents below one half clamp the rate power; above-range exponents
        load_settings(31'd1048576, 31'd2097152, 31'd1048576, 31'd3145728,
                      21'h1F_FFFF, 15'd0, 16'd4096);
        send_item(32'h0000_1000, 32'hFFFF_F000, 5, 6);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 7, 8);
        drain();
        load_settings(31'd4194304, 31'd4194304, 31'd5242880, 31'd5242880,
                      21'd1048576, 15'h7FFF, 16'hFFFF);
        send_item(32'h0020_0000, 32'hFFE0_0000, 9, 10);
        send_item(-7, 7, 11, 12);
        drain();

        // random phases, extremes of the ranges among them
        gaps_on = 1;
        load_settings(31'd4194304, 31'd4194304, 31'd5242880, 31'd5242880,
                      21'd20972, 15'd11469, 16'd19661);
        random_items(90);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            load_settings($urandom_range(0, 9) == 0 ? 31'h7FFF_FFFF
                                                    : 31'($urandom_range(0, 1 << 24)),
                          $urandom_range(0, 9) == 0 ? 31'd0
                                                    : 31'($urandom_range(0, 1 << 24)),
                          $urandom_range(0, 9) == 0 ? 31'h7FFF_FFFF
                                                    : 31'($urandom_range(0, 1 << 24)),
                          $urandom_range(0, 9) == 0 ? 31'd0
                                                    : 31'($urandom_range(0, 1 << 24)),
                          ph == 2 ? 21'd1 : 21'($urandom_range(1, 1 << 20)),
                          ph == 3 ? 15'd8192 : 15'($urandom_range(8192, 16384)),
                          ph == 3 ? 16'd32768 : 16'($urandom_range(16384, 32768)));
            gaps_on = (ph != 4);
            random_items(70);
            drain();
        end

        $display("covered %0d results over %0d register settings", checked, settings_run);
        $display("directed extremes, zero step, clamped and over-range exponents, saturation");
        if (errors == 0) begin
            $display("PASS finite_time_tracking_differentiator_top");
        end else begin
            $display("FAIL finite_time_tracking_differentiator_top");
        end
        $finish;
    end

endmodule
